>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b, msg)
`define ASSERT_NEXT(label, clk, rst_n, a, b, msg)
`endif
`endif

>>> design/stac_pkg.sv
// ----------------------------------------------------------------------------
// stac_pkg
// Types, constants and saturating helpers for the statistics accumulator.
// ----------------------------------------------------------------------------
package stac_pkg;

  localparam int DEF_SLOT_COUNT    = 16;
  localparam int DEF_ELEMENT_COUNT = 8;

  localparam int SAMPLE_BITS = 24;
  localparam int SUM_BITS    = 48;
  localparam int SQ_BITS     = 64;
  localparam int CNT_BITS    = 24;
  localparam int MRG_BITS    = 16;
  localparam int DEV_BITS    = 23;
  localparam int EIU_BITS    = 4;
  localparam int WALK_BITS   = 7;   // holds element counts up to 127

  localparam logic [EIU_BITS-1:0]    EIU_RESET = 4'd8;
  localparam logic [SAMPLE_BITS-1:0] VAL_MAX   = 24'h7F_FFFF;
  localparam logic [SAMPLE_BITS-1:0] VAL_MIN   = 24'h80_0000;
  localparam logic [SUM_BITS-1:0]    SUM_MAX   = 48'h7FFF_FFFF_FFFF;
  localparam logic [SUM_BITS-1:0]    SUM_MIN   = 48'h8000_0000_0000;
  localparam logic [CNT_BITS-1:0]    CNT_MAX   = 24'hFF_FFFF;
  localparam logic [MRG_BITS-1:0]    MRG_MAX   = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_MERGE = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_MRG_CNT,
    S_MRG_UPD,
    S_MRG_SRC,
    S_MRG_DST,
    S_MRG_WR,
    S_CLR,
    S_RD_MEM,
    S_RD_CAP,
    S_RD_DIV1,
    S_RD_MUL,
    S_RD_DIV2,
    S_RD_SQRT,
    S_RD_OUT
  } state_e;

  typedef struct packed {
    op_e                      op;
    logic [3:0]               slot;
    logic [3:0]               source_slot;
    logic [2:0]               element;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                     tuple_end;
  } in_item_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]           tuple_count;
    logic [MRG_BITS-1:0]           merge_count;
    logic signed [SAMPLE_BITS-1:0] mean;
    logic [DEV_BITS-1:0]           deviation;
    logic signed [SAMPLE_BITS-1:0] largest;
    logic signed [SAMPLE_BITS-1:0] smallest;
  } out_item_t;

  // one element entry of the statistics memory
  typedef struct packed {
    logic                          seen;
    logic [SUM_BITS-1:0]           sum;
    logic [SQ_BITS-1:0]            sq;
    logic signed [SAMPLE_BITS-1:0] mx;
    logic signed [SAMPLE_BITS-1:0] mn;
  } cell_t;

  // signed 48-bit add, clipped to range
  function automatic logic [SUM_BITS-1:0] sat_sum(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] r;
    r = {a[SUM_BITS-1], a} + {b[SUM_BITS-1], b};
    if (r[SUM_BITS] != r[SUM_BITS-1]) begin
      return r[SUM_BITS] ? SUM_MIN : SUM_MAX;
    end
    return r[SUM_BITS-1:0];
  endfunction

  // unsigned 64-bit add, clipped at all ones
  function automatic logic [SQ_BITS-1:0] sat_sq(input logic [SQ_BITS-1:0] a,
                                                input logic [SQ_BITS-1:0] b);
    logic [SQ_BITS:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[SQ_BITS] ? {SQ_BITS{1'b1}} : r[SQ_BITS-1:0];
  endfunction

  // unsigned 24-bit count add, clipped
  function automatic logic [CNT_BITS-1:0] sat_cnt(input logic [CNT_BITS-1:0] a,
                                                  input logic [CNT_BITS-1:0] b);
    logic [CNT_BITS:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[CNT_BITS] ? CNT_MAX : r[CNT_BITS-1:0];
  endfunction

endpackage

>>> design/stac_mem.sv
// ----------------------------------------------------------------------------
// stac_mem
// Element statistics memory: one write, one registered read, per-entry valid
// bits so that reset and slot clear read back as an empty entry.
// ----------------------------------------------------------------------------
module stac_mem #(
  parameter int SLOT_COUNT    = stac_pkg::DEF_SLOT_COUNT,
  parameter int ELEMENT_COUNT = stac_pkg::DEF_ELEMENT_COUNT,
  localparam int CELLS = SLOT_COUNT * ELEMENT_COUNT,
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [AW-1:0]   rd_addr_i,
  output stac_pkg::cell_t rd_data_o,
  input  logic            wr_en_i,
  input  logic [AW-1:0]   wr_addr_i,
  input  stac_pkg::cell_t wr_data_i,
  input  logic            clr_en_i,
  input  logic [SW-1:0]   clr_slot_i
);

  stac_pkg::cell_t mem_q [CELLS];
  stac_pkg::cell_t rd_q;
  logic [CELLS-1:0] valid_q;
  logic             rd_valid_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // valid bits: set on write, cleared per slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (clr_en_i) begin
        for (int c = 0; c < CELLS; c++) begin
          if (c / ELEMENT_COUNT == int'(clr_slot_i)) begin
            valid_q[c] <= 1'b0;
          end
        end
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_valid_q ? rd_q : '0;

endmodule

>>> design/stac_div.sv
// ----------------------------------------------------------------------------
// stac_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stac_div #(
  parameter int DW = stac_pkg::SQ_BITS,
  parameter int VW = stac_pkg::CNT_BITS,
  localparam int CW = $clog2(DW + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, rem_d, dvs_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   shifted, diff;
  logic          ge;

  // one trial subtraction
  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dvs_q};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? diff[VW-1:0] : shifted[VW-1:0];
  end

  // sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> design/stac_sqrt.sv
// ----------------------------------------------------------------------------
// stac_sqrt
// Floored integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module stac_sqrt #(
  parameter int W = stac_pkg::SQ_BITS,
  localparam int RW = W / 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [W-1:0]  radicand_i,
  output logic          done_o,
  output logic [RW-1:0] root_o
);

  logic [W-1:0] v_q, r_q, bit_q, trial;
  logic         busy_q, done_q, ge;

  assign trial = r_q + bit_q;
  assign ge    = v_q >= trial;

  // sequencing: stop after the lowest bit position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= radicand_i;
      r_q   <= '0;
      bit_q <= W'(1) << (W - 2);
    end else if (busy_q) begin
      v_q   <= ge ? v_q - trial : v_q;
      r_q   <= ge ? (r_q >> 1) + bit_q : r_q >> 1;
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign root_o = r_q[RW-1:0];

endmodule

>>> design/slotted_tuple_statistics_accumulator_unit.sv
// ----------------------------------------------------------------------------
// slotted_tuple_statistics_accumulator_unit
// Per-slot running sum, sum of squares, max and min with add, merge, read and
// clear, kept in one read-modify-write element memory.
// ----------------------------------------------------------------------------
// Add: an entry read, then its write; clear: the slot's counts and valid bits;
//   merge: counts, then per element walked a source read, a destination read
//   and a write on the one memory. Read: an empty or out-of-range slot skips
//   the two divides in the shared iterative divider and the iterative root.
// One item at a time; the result register lets the next item in while it waits.
// Reset (async, active low) empties every slot at once through valid bits.
module slotted_tuple_statistics_accumulator_unit #(
  parameter int SLOT_COUNT    = stac_pkg::DEF_SLOT_COUNT,
  parameter int ELEMENT_COUNT = stac_pkg::DEF_ELEMENT_COUNT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  stac_pkg::in_item_t              in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output stac_pkg::out_item_t             out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [stac_pkg::EIU_BITS-1:0]   cfg_data_i
);

  `include "assert_macros.svh"

  localparam int CELLS = SLOT_COUNT * ELEMENT_COUNT;
  localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int SW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int WB    = stac_pkg::WALK_BITS;

  stac_pkg::state_e   state_q, state_d;
  stac_pkg::in_item_t item_q;
  stac_pkg::out_item_t out_q;
  logic               out_valid_q;
  logic [stac_pkg::EIU_BITS-1:0] eiu_q;
  logic [WB-1:0]      i_q, n_eff;

  logic [stac_pkg::CNT_BITS-1:0] tc_q [SLOT_COUNT];
  logic [stac_pkg::MRG_BITS-1:0] mc_q [SLOT_COUNT];

  // payload registers
  logic [47:0]                      sqx_q, m2_q;
  logic [stac_pkg::CNT_BITS-1:0]    cnt_src_q, cnt_q;
  logic [stac_pkg::MRG_BITS-1:0]    mrg_q;
  stac_pkg::cell_t                  src_q;
  logic                             sneg_q;
  logic [stac_pkg::SQ_BITS-1:0]     sq_q;
  logic signed [stac_pkg::SAMPLE_BITS-1:0] lg_q, sm_q, mean_q;
  logic [stac_pkg::DEV_BITS-1:0]    dev_q;

  // item decode
  logic in_accept, in_cell_ok, in_mrg_ok, in_slot_ok, cell_ok, out_free;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_slot_ok = 32'(in_data_i.slot) < SLOT_COUNT;
  assign in_cell_ok = in_slot_ok && (32'(in_data_i.element) < ELEMENT_COUNT);
  assign in_mrg_ok  = in_slot_ok && (32'(in_data_i.source_slot) < SLOT_COUNT);
  assign cell_ok    = (32'(item_q.slot) < SLOT_COUNT)
                      && (32'(item_q.element) < ELEMENT_COUNT);
  assign out_free   = !out_valid_q || !out_stall_i;

  assign n_eff = (WB'(eiu_q) > WB'(ELEMENT_COUNT)) ? WB'(ELEMENT_COUNT) : WB'(eiu_q);

  // count store read port
  logic [SW-1:0] cnt_slot, dst_slot;
  logic [stac_pkg::CNT_BITS-1:0] tc_rd;
  logic [stac_pkg::MRG_BITS-1:0] mc_rd;
  assign dst_slot = SW'(item_q.slot);
  assign cnt_slot = (state_q == stac_pkg::S_MRG_CNT) ? SW'(item_q.source_slot) : dst_slot;
  assign tc_rd    = tc_q[cnt_slot];
  assign mc_rd    = mc_q[cnt_slot];

  // memory addresses
  logic [AW-1:0] cell_addr, src_addr, dst_addr, rd_addr, wr_addr;
  assign cell_addr = AW'(AW'(item_q.slot) * AW'(ELEMENT_COUNT) + AW'(item_q.element));
  assign src_addr  = AW'(AW'(item_q.source_slot) * AW'(ELEMENT_COUNT) + AW'(i_q));
  assign dst_addr  = AW'(AW'(item_q.slot) * AW'(ELEMENT_COUNT) + AW'(i_q));
  assign rd_addr   = (state_q == stac_pkg::S_MRG_SRC) ? src_addr :
                     (state_q == stac_pkg::S_MRG_DST) ? dst_addr : cell_addr;
  assign wr_addr   = (state_q == stac_pkg::S_MRG_WR) ? dst_addr : cell_addr;

  logic            rd_en, wr_en, clr_en, div_start, sqrt_start;
  stac_pkg::cell_t rd_data, wr_data, add_cell, mrg_cell;

  stac_mem #(
    .SLOT_COUNT   (SLOT_COUNT),
    .ELEMENT_COUNT(ELEMENT_COUNT)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .clr_en_i  (clr_en),
    .clr_slot_i(dst_slot)
  );

  // add update of one entry
  logic [stac_pkg::SAMPLE_BITS-1:0] smag;
  assign smag = item_q.sample[stac_pkg::SAMPLE_BITS-1] ? 24'(-item_q.sample)
                                                       : 24'(item_q.sample);
  always_comb begin
    add_cell      = rd_data;
    add_cell.sum  = stac_pkg::sat_sum(rd_data.sum,
                      {{24{item_q.sample[stac_pkg::SAMPLE_BITS-1]}}, item_q.sample});
    add_cell.sq   = stac_pkg::sat_sq(rd_data.sq, 64'(sqx_q));
    add_cell.seen = 1'b1;
    if (!rd_data.seen) begin
      add_cell.mx = item_q.sample;
      add_cell.mn = item_q.sample;
    end else begin
      if (item_q.sample > rd_data.mx) add_cell.mx = item_q.sample;
      if (item_q.sample < rd_data.mn) add_cell.mn = item_q.sample;
    end
  end

  // merge of source entry into destination entry
  always_comb begin
    mrg_cell     = rd_data;
    mrg_cell.sum = stac_pkg::sat_sum(rd_data.sum, src_q.sum);
    mrg_cell.sq  = stac_pkg::sat_sq(rd_data.sq, src_q.sq);
    if (src_q.seen) begin
      mrg_cell.seen = 1'b1;
      if (!rd_data.seen) begin
        mrg_cell.mx = src_q.mx;
        mrg_cell.mn = src_q.mn;
      end else begin
        if (src_q.mx > rd_data.mx) mrg_cell.mx = src_q.mx;
        if (src_q.mn < rd_data.mn) mrg_cell.mn = src_q.mn;
      end
    end
  end

  assign wr_data = (state_q == stac_pkg::S_MRG_WR) ? mrg_cell : add_cell;

  // divide and root units
  logic [stac_pkg::SQ_BITS-1:0]  div_dividend, div_quo, sqrt_in;
  logic [stac_pkg::CNT_BITS-1:0] div_divisor;
  logic [stac_pkg::SUM_BITS-1:0] sum_mag;
  logic                          div_busy, div_done, sqrt_done;
  logic [31:0]                   root;

  assign sum_mag      = rd_data.sum[stac_pkg::SUM_BITS-1] ? 48'(-rd_data.sum)
                                                          : rd_data.sum;
  assign div_dividend = (state_q == stac_pkg::S_RD_CAP) ? 64'(sum_mag) : sq_q;
  assign div_divisor  = (state_q == stac_pkg::S_RD_CAP) ? tc_rd : cnt_q;
  assign sqrt_in      = (div_quo > 64'(m2_q)) ? div_quo - 64'(m2_q) : '0;

  stac_div #(
    .DW(stac_pkg::SQ_BITS),
    .VW(stac_pkg::CNT_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .busy_o    (div_busy),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  stac_sqrt #(
    .W(stac_pkg::SQ_BITS)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (sqrt_start),
    .radicand_i(sqrt_in),
    .done_o    (sqrt_done),
    .root_o    (root)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      stac_pkg::S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.op)
            stac_pkg::OP_ADD:   state_d = in_cell_ok ? stac_pkg::S_ADD_RD : stac_pkg::S_IDLE;
            stac_pkg::OP_MERGE: state_d = in_mrg_ok ? stac_pkg::S_MRG_CNT : stac_pkg::S_IDLE;
            stac_pkg::OP_READ:  state_d = stac_pkg::S_RD_MEM;
            stac_pkg::OP_CLEAR: state_d = in_slot_ok ? stac_pkg::S_CLR : stac_pkg::S_IDLE;
            default:            state_d = stac_pkg::S_IDLE;
          endcase
        end
      end
      stac_pkg::S_ADD_RD:  state_d = stac_pkg::S_ADD_WR;
      stac_pkg::S_ADD_WR:  state_d = stac_pkg::S_IDLE;
      stac_pkg::S_MRG_CNT: state_d = stac_pkg::S_MRG_UPD;
      stac_pkg::S_MRG_UPD: state_d = (n_eff == '0) ? stac_pkg::S_IDLE : stac_pkg::S_MRG_SRC;
      stac_pkg::S_MRG_SRC: state_d = stac_pkg::S_MRG_DST;
      stac_pkg::S_MRG_DST: state_d = stac_pkg::S_MRG_WR;
      stac_pkg::S_MRG_WR:  state_d = (i_q + 1'b1 == n_eff) ? stac_pkg::S_IDLE
                                                           : stac_pkg::S_MRG_SRC;
      stac_pkg::S_CLR:     state_d = stac_pkg::S_IDLE;
      stac_pkg::S_RD_MEM:  state_d = stac_pkg::S_RD_CAP;
      stac_pkg::S_RD_CAP:  state_d = (cell_ok && tc_rd != '0) ? stac_pkg::S_RD_DIV1
                                                              : stac_pkg::S_RD_OUT;
      stac_pkg::S_RD_DIV1: state_d = div_done ? stac_pkg::S_RD_MUL : stac_pkg::S_RD_DIV1;
      stac_pkg::S_RD_MUL:  state_d = stac_pkg::S_RD_DIV2;
      stac_pkg::S_RD_DIV2: state_d = div_done ? stac_pkg::S_RD_SQRT : stac_pkg::S_RD_DIV2;
      stac_pkg::S_RD_SQRT: state_d = sqrt_done ? stac_pkg::S_RD_OUT : stac_pkg::S_RD_SQRT;
      stac_pkg::S_RD_OUT:  state_d = out_free ? stac_pkg::S_IDLE : stac_pkg::S_RD_OUT;
      default:             state_d = stac_pkg::S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall_o = 1'b1;
    rd_en      = 1'b0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state_q)
      stac_pkg::S_IDLE:    in_stall_o = 1'b0;
      stac_pkg::S_ADD_RD:  rd_en = 1'b1;
      stac_pkg::S_ADD_WR:  wr_en = 1'b1;
      stac_pkg::S_MRG_SRC: rd_en = 1'b1;
      stac_pkg::S_MRG_DST: rd_en = 1'b1;
      stac_pkg::S_MRG_WR:  wr_en = 1'b1;
      stac_pkg::S_CLR:     clr_en = 1'b1;
      stac_pkg::S_RD_MEM:  rd_en = cell_ok;
      stac_pkg::S_RD_CAP:  div_start = cell_ok && (tc_rd != '0);
      stac_pkg::S_RD_MUL:  div_start = 1'b1;
      stac_pkg::S_RD_DIV2: sqrt_start = div_done;
      default: begin
      end
    endcase
  end

  // control registers and count store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= stac_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      eiu_q       <= stac_pkg::EIU_RESET;
      i_q         <= '0;
      for (int s = 0; s < SLOT_COUNT; s++) begin
        tc_q[s] <= '0;
        mc_q[s] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        eiu_q <= cfg_data_i;
      end
      if (state_q == stac_pkg::S_RD_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        stac_pkg::S_ADD_WR: begin
          if (item_q.tuple_end) begin
            tc_q[dst_slot] <= stac_pkg::sat_cnt(tc_rd, 24'd1);
          end
        end
        stac_pkg::S_MRG_UPD: begin
          tc_q[dst_slot] <= stac_pkg::sat_cnt(tc_rd, cnt_src_q);
          mc_q[dst_slot] <= (mc_rd == stac_pkg::MRG_MAX) ? mc_rd : mc_rd + 1'b1;
          i_q            <= '0;
        end
        stac_pkg::S_MRG_WR: i_q <= i_q + 1'b1;
        stac_pkg::S_CLR: begin
          tc_q[dst_slot] <= '0;
          mc_q[dst_slot] <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  logic [stac_pkg::SAMPLE_BITS-1:0] mean_mag;
  assign mean_mag = mean_q[stac_pkg::SAMPLE_BITS-1] ? 24'(-mean_q) : 24'(mean_q);

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q <= in_data_i;
    end
    case (state_q)
      stac_pkg::S_ADD_RD:  sqx_q <= smag * smag;
      stac_pkg::S_MRG_CNT: cnt_src_q <= tc_rd;
      stac_pkg::S_MRG_DST: src_q <= rd_data;
      stac_pkg::S_RD_CAP: begin
        cnt_q  <= cell_ok ? tc_rd : '0;
        mrg_q  <= cell_ok ? mc_rd : '0;
        sneg_q <= rd_data.sum[stac_pkg::SUM_BITS-1];
        sq_q   <= rd_data.sq;
        lg_q   <= (cell_ok && rd_data.seen) ? rd_data.mx : '0;
        sm_q   <= (cell_ok && rd_data.seen) ? rd_data.mn : '0;
        mean_q <= '0;
        dev_q  <= '0;
      end
      stac_pkg::S_RD_DIV1: begin
        if (div_done) begin
          if (sneg_q) begin
            mean_q <= (div_quo > 64'(stac_pkg::VAL_MIN)) ? stac_pkg::VAL_MIN
                                                         : 24'(-div_quo[23:0]);
          end else begin
            mean_q <= (div_quo > 64'(stac_pkg::VAL_MAX)) ? stac_pkg::VAL_MAX
                                                         : div_quo[23:0];
          end
        end
      end
      stac_pkg::S_RD_MUL:  m2_q <= mean_mag * mean_mag;
      stac_pkg::S_RD_SQRT: begin
        if (sqrt_done) begin
          dev_q <= (root > 32'(stac_pkg::VAL_MAX)) ? stac_pkg::VAL_MAX[22:0] : root[22:0];
        end
      end
      stac_pkg::S_RD_OUT: begin
        if (out_free) begin
          out_q.tuple_count <= cnt_q;
          out_q.merge_count <= mrg_q;
          out_q.mean        <= mean_q;
          out_q.deviation   <= dev_q;
          out_q.largest     <= lg_q;
          out_q.smallest    <= sm_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  // checks
  `ASSERT_NEXT(a_out_from_read, clk_i, rst_ni, (state_q != stac_pkg::S_RD_OUT) && !out_valid_q, !out_valid_q, "result beat without a read")
  `ASSERT_IMPLIES(a_wr_state, clk_i, rst_ni, wr_en, (state_q == stac_pkg::S_ADD_WR) || (state_q == stac_pkg::S_MRG_WR), "memory write outside update state")
  `ASSERT_IMPLIES(a_walk_bound, clk_i, rst_ni, state_q == stac_pkg::S_MRG_WR, i_q < n_eff, "merge walk past element count")
  `ASSERT_IMPLIES(a_div_idle, clk_i, rst_ni, div_start, !div_busy, "divider restarted while busy")

endmodule

>>> verif/stac_checker.sv
// ----------------------------------------------------------------------------
// stac_checker
// Watches the item, result and register channels of the statistics
// accumulator. It keeps its own copy of every slot and element, works out the
// result of each accepted read beat and compares it field by field.
// ----------------------------------------------------------------------------
module stac_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  stac_pkg::in_item_t            in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  stac_pkg::out_item_t           out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [stac_pkg::EIU_BITS-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o,
  output int                            reads_checked_o
);

  localparam int SLOTS = stac_pkg::DEF_SLOT_COUNT;
  localparam int ELEMS = stac_pkg::DEF_ELEMENT_COUNT;
  localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SUM_LO = -SUM_HI - 1;
  localparam longint MEAN_HI = 64'sd8388607;
  localparam longint MEAN_LO = -64'sd8388608;

  // shadow of the accumulator state
  logic [stac_pkg::CNT_BITS-1:0]           tuples [SLOTS];
  logic [stac_pkg::MRG_BITS-1:0]           merges [SLOTS];
  longint                                  sums   [SLOTS*ELEMS];
  logic [stac_pkg::SQ_BITS-1:0]            sqsums [SLOTS*ELEMS];
  logic signed [stac_pkg::SAMPLE_BITS-1:0] hi_val [SLOTS*ELEMS];
  logic signed [stac_pkg::SAMPLE_BITS-1:0] lo_val [SLOTS*ELEMS];
  logic                                    seen   [SLOTS*ELEMS];
  logic [stac_pkg::EIU_BITS-1:0]           walk_len;

  stac_pkg::out_item_t expected_reads[$];

  function automatic longint clip_sum(input longint a, input longint b);
    longint r;
    r = a + b;
    if (r > SUM_HI) return SUM_HI;
    if (r < SUM_LO) return SUM_LO;
    return r;
  endfunction

  function automatic logic [stac_pkg::SQ_BITS-1:0] clip_sq(
      input logic [stac_pkg::SQ_BITS-1:0] a, input logic [stac_pkg::SQ_BITS-1:0] b);
    logic [stac_pkg::SQ_BITS:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[stac_pkg::SQ_BITS] ? {stac_pkg::SQ_BITS{1'b1}} : r[stac_pkg::SQ_BITS-1:0];
  endfunction

  function automatic logic [stac_pkg::CNT_BITS-1:0] clip_count(
      input logic [stac_pkg::CNT_BITS-1:0] a, input logic [stac_pkg::CNT_BITS-1:0] b);
    logic [stac_pkg::CNT_BITS:0] r;
    r = {1'b0, a} + {1'b0, b};
    return r[stac_pkg::CNT_BITS] ? stac_pkg::CNT_MAX : r[stac_pkg::CNT_BITS-1:0];
  endfunction

  // floored square root, two bits per step
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] probe;
    root  = 0;
    probe = 64'd1 << 62;
    while (probe > v) probe = probe >> 2;
    while (probe != 0) begin
      if (v >= root + probe) begin
        v    = v - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  function automatic void empty_slot(input int s);
    tuples[s] = '0;
    merges[s] = '0;
    for (int e = 0; e < ELEMS; e++) begin
      sums[s*ELEMS+e]   = 0;
      sqsums[s*ELEMS+e] = '0;
      hi_val[s*ELEMS+e] = '0;
      lo_val[s*ELEMS+e] = '0;
      seen[s*ELEMS+e]   = 1'b0;
    end
  endfunction

  // statistics of one element as a read reports them
  function automatic stac_pkg::out_item_t element_stats(input int s, input int c);
    stac_pkg::out_item_t r;
    longint      sm;
    longint      mag;
    longint      q;
    longint      mean;
    logic [63:0] m2;
    logic [63:0] avg_sq;
    logic [63:0] dev;
    r = '0;
    r.tuple_count = tuples[s];
    r.merge_count = merges[s];
    if (tuples[s] != 0) begin
      sm  = sums[c];
      mag = (sm < 0) ? -sm : sm;
      q   = mag / longint'(tuples[s]);
      if (sm < 0) mean = (q > -MEAN_LO) ? MEAN_LO : -q;
      else        mean = (q > MEAN_HI) ? MEAN_HI : q;
      m2     = 64'(mean * mean);
      avg_sq = sqsums[c] / {40'd0, tuples[s]};
      dev    = floor_root((avg_sq > m2) ? avg_sq - m2 : 64'd0);
      if (dev > 64'(MEAN_HI)) dev = 64'(MEAN_HI);
      r.mean      = mean[stac_pkg::SAMPLE_BITS-1:0];
      r.deviation = dev[stac_pkg::DEV_BITS-1:0];
    end
    if (seen[c]) begin
      r.largest  = hi_val[c];
      r.smallest = lo_val[c];
    end
    return r;
  endfunction

  // apply one accepted beat; reads queue their expected result
  function automatic void apply_beat(input stac_pkg::in_item_t it);
    int          s;
    int          src;
    int          c;
    int          n;
    int          d;
    int          f;
    longint      x;
    longint      fsum;
    logic [63:0] fsq;
    logic signed [stac_pkg::SAMPLE_BITS-1:0] fhi;
    logic signed [stac_pkg::SAMPLE_BITS-1:0] flo;
    logic        fseen;
    s   = it.slot;
    src = it.source_slot;
    c   = s*ELEMS + it.element;
    case (it.op)
      stac_pkg::OP_ADD: begin
        x         = longint'(it.sample);
        sums[c]   = clip_sum(sums[c], x);
        sqsums[c] = clip_sq(sqsums[c], 64'((x < 0 ? -x : x) * (x < 0 ? -x : x)));
        if (!seen[c]) begin
          hi_val[c] = it.sample;
          lo_val[c] = it.sample;
          seen[c]   = 1'b1;
        end else begin
          if (it.sample > hi_val[c]) hi_val[c] = it.sample;
          if (it.sample < lo_val[c]) lo_val[c] = it.sample;
        end
        if (it.tuple_end) tuples[s] = clip_count(tuples[s], 24'd1);
      end
      stac_pkg::OP_MERGE: begin
        n = (walk_len > ELEMS) ? ELEMS : walk_len;
        tuples[s] = clip_count(tuples[s], tuples[src]);
        if (merges[s] != stac_pkg::MRG_MAX) merges[s] = merges[s] + 1'b1;
        for (int i = 0; i < n; i++) begin
          d     = s*ELEMS + i;
          f     = src*ELEMS + i;
          fsum  = sums[f];
          fsq   = sqsums[f];
          fhi   = hi_val[f];
          flo   = lo_val[f];
          fseen = seen[f];
          sums[d]   = clip_sum(sums[d], fsum);
          sqsums[d] = clip_sq(sqsums[d], fsq);
          if (fseen) begin
            if (!seen[d]) begin
              hi_val[d] = fhi;
              lo_val[d] = flo;
              seen[d]   = 1'b1;
            end else begin
              if (fhi > hi_val[d]) hi_val[d] = fhi;
              if (flo < lo_val[d]) lo_val[d] = flo;
            end
          end
        end
      end
      stac_pkg::OP_CLEAR: empty_slot(s);
      default:  expected_reads.push_back(element_stats(s, c));
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    $display("mismatch in %s: got %0h, expected %0h", field, got, want);
    fail_count_o++;
  endtask

  // compare first, then predict: a result never belongs to the beat of its own edge
  always @(posedge clk_i or negedge rst_ni) begin
    stac_pkg::out_item_t want;
    if (!rst_ni) begin
      for (int s = 0; s < SLOTS; s++) empty_slot(s);
      walk_len = stac_pkg::EIU_RESET;
      expected_reads.delete();
      fail_count_o    = 0;
      reads_checked_o = 0;
      pending_o       = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_reads.size() == 0) begin
          report_mismatch("unexpected result beat", 0, 0);
        end else begin
          want = expected_reads.pop_front();
          reads_checked_o++;
          if (out_data_i.tuple_count != want.tuple_count)
            report_mismatch("tuple_count", out_data_i.tuple_count, want.tuple_count);
          if (out_data_i.merge_count != want.merge_count)
            report_mismatch("merge_count", out_data_i.merge_count, want.merge_count);
          if (out_data_i.mean != want.mean)
            report_mismatch("mean", out_data_i.mean, want.mean);
          if (out_data_i.deviation != want.deviation)
            report_mismatch("deviation", out_data_i.deviation, want.deviation);
          if (out_data_i.largest != want.largest)
            report_mismatch("largest", out_data_i.largest, want.largest);
          if (out_data_i.smallest != want.smallest)
            report_mismatch("smallest", out_data_i.smallest, want.smallest);
        end
      end
      if (in_valid_i && !in_stall_i) apply_beat(in_data_i);
      if (cfg_valid_i && cfg_ready_i) walk_len = cfg_data_i;
      pending_o = expected_reads.size();
    end
  end

endmodule

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the statistics accumulator: directed corner beats,
// saturation runs, random tuple traffic under several walk lengths, random
// idling on both channels, a long result hold-off and a drained pause.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 3000000;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  stac_pkg::in_item_t            in_data;
  logic                          out_valid;
  logic                          out_stall;
  stac_pkg::out_item_t           out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [stac_pkg::EIU_BITS-1:0] cfg_data;

  int fail_count;
  int pending;
  int reads_checked;
  int beats_sent;
  int cycles;
  bit idle_on;
  bit hold_rx;

  slotted_tuple_statistics_accumulator_unit u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  stac_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .reads_checked_o (reads_checked)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stall per beat, one long hold-off on request
  initial begin
    int gap;
    out_stall = 1'b1;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (hold_rx) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        hold_rx = 1'b0;
      end
      gap = idle_on ? $urandom_range(0, 15) : 0;
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  function automatic stac_pkg::in_item_t make_item(input stac_pkg::op_e op, input int s,
                                                   input int src, input int e,
                                                   input int smp, input bit last);
    stac_pkg::in_item_t it;
    it.op          = op;
    it.slot        = 4'(s);
    it.source_slot = 4'(src);
    it.element     = 3'(e);
    it.sample      = stac_pkg::SAMPLE_BITS'(smp);
    it.tuple_end   = last;
    return it;
  endfunction

  function automatic int pick_sample();
    case ($urandom_range(0, 5))
      0:       return 8388607;
      1:       return -8388608;
      2:       return $urandom_range(0, 200) - 100;
      default: return int'($urandom);
    endcase
  endfunction

  // one beat on the item channel; called and left at a falling edge
  task automatic send_beat(input stac_pkg::in_item_t it);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    beats_sent++;
    @(negedge clk);
  endtask

  // wait until every read is answered and the last merge has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (40) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_walk_len(input int v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= stac_pkg::EIU_BITS'(v);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // random tuple traffic, mostly well formed
  task automatic random_traffic(input int count, input int hold_at);
    int s;
    int len;
    int k;
    bit held;
    k    = 0;
    held = 1'b0;
    while (k < count) begin
      idle_on = ((k / 200) % 2) == 0;
      if (!held && hold_at >= 0 && k >= hold_at) begin
        hold_rx = 1'b1;
        held    = 1'b1;
      end
      s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: begin
          // a whole tuple into one slot
          len = $urandom_range(1, 8);
          for (int e = 0; e < len; e++)
            send_beat(make_item(stac_pkg::OP_ADD, s, $urandom_range(0, 15), e,
                                pick_sample(), e == len - 1));
          k += len;
        end
        4: begin
          send_beat(make_item(stac_pkg::OP_ADD, s, $urandom_range(0, 15),
                              $urandom_range(0, 7), pick_sample(), $urandom_range(0, 1)));
          k++;
        end
        5, 6: begin
          send_beat(make_item(stac_pkg::OP_READ, s, $urandom_range(0, 15),
                              $urandom_range(0, 7), pick_sample(), $urandom_range(0, 1)));
          k++;
        end
        7, 8: begin
          send_beat(make_item(stac_pkg::OP_MERGE, s, $urandom_range(0, 15),
                              $urandom_range(0, 7), pick_sample(), $urandom_range(0, 1)));
          k++;
        end
        default: begin
          send_beat(make_item(stac_pkg::OP_CLEAR, s, $urandom_range(0, 15),
                              $urandom_range(0, 7), pick_sample(), $urandom_range(0, 1)));
          k++;
        end
      endcase
    end
  endtask

  // main sequence
  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    idle_on   = 1'b1;
    hold_rx   = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: extremes, first value, empty reads, mean and spread clipping
    send_beat(make_item(stac_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 0, 0, 0, 8388607, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 0, 0, 0, -8388608, 1));
    send_beat(make_item(stac_pkg::OP_ADD, 0, 15, 7, -5, 1));
    send_beat(make_item(stac_pkg::OP_READ, 0, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 0, 0, 7, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 0, 0, 3, 0, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 15, 0, 7, 8388607, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 15, 0, 7, 8388607, 1));
    send_beat(make_item(stac_pkg::OP_READ, 15, 0, 7, 0, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 14, 0, 2, -8388608, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 14, 0, 2, -8388608, 1));
    send_beat(make_item(stac_pkg::OP_READ, 14, 0, 2, 0, 0));
    send_beat(make_item(stac_pkg::OP_MERGE, 1, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 1, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_MERGE, 1, 1, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 1, 0, 7, 0, 0));
    send_beat(make_item(stac_pkg::OP_MERGE, 15, 14, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 15, 0, 2, 0, 0));
    send_beat(make_item(stac_pkg::OP_CLEAR, 0, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 0, 0, 0, 0, 0));

    // self merges until counts, sums and squares clip
    idle_on = 1'b0;
    send_beat(make_item(stac_pkg::OP_ADD, 9, 0, 0, 8388607, 1));
    send_beat(make_item(stac_pkg::OP_ADD, 9, 0, 1, -8388608, 1));
    for (int i = 0; i < 26; i++) send_beat(make_item(stac_pkg::OP_MERGE, 9, 9, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 9, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 9, 0, 1, 0, 0));
    send_beat(make_item(stac_pkg::OP_MERGE, 8, 9, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 8, 0, 1, 0, 0));

    // random traffic under several walk lengths, long hold-off in the second
    write_walk_len(3);
    random_traffic(550, -1);
    write_walk_len(15);
    random_traffic(550, 250);
    drain();
    write_walk_len(1);
    random_traffic(550, -1);
    write_walk_len(8);

    // walk length zero: counts merge, no element is walked
    write_walk_len(0);
    idle_on = 1'b0;
    send_beat(make_item(stac_pkg::OP_CLEAR, 5, 0, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_ADD, 6, 0, 0, 77, 1));
    for (int i = 0; i < 20; i++) send_beat(make_item(stac_pkg::OP_MERGE, 5, 6, 0, 0, 0));
    send_beat(make_item(stac_pkg::OP_READ, 5, 0, 0, 0, 0));

    // final wait for the slowest read
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (300) @(posedge clk);
    $display("run covered %0d item beats and %0d read results over walk lengths",
             beats_sent, reads_checked);
    $display("8, 3, 15, 1 and 0, with count, sum and square clipping");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> slotted_tuple_statistics_accumulator_unit.f
+incdir+design
design/stac_pkg.sv
design/stac_mem.sv
design/stac_div.sv
design/stac_sqrt.sv
design/slotted_tuple_statistics_accumulator_unit.sv
verif/stac_checker.sv
verif/tb_top.sv
